@@ rtl/rpc_bind_ack_parser_unit_macros.svh @@
// Assertion macros shared by the bind acknowledge parser RTL.
`ifndef RPC_BIND_ACK_PARSER_UNIT_MACROS_SVH
`define RPC_BIND_ACK_PARSER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define RBAP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bind acknowledge parser assertion failed");
// Check a property on every clock edge, reset included.
`define RBAP_ASSERT_NR(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bind acknowledge parser reset assertion failed");
`else
`define RBAP_ASSERT(lbl, prop)
`define RBAP_ASSERT_NR(lbl, prop)
`endif
`endif

@@ rtl/rbap_pkg.sv @@
// Types and constants for the bind acknowledge parser.
`default_nettype none
package rbap_pkg;

    // One received byte of the PDU.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rbap_in_t;

    // One parse result, given at frame end.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] max_transmit;
        logic [15:0] max_receive;
        logic [31:0] assoc_group;
        logic [15:0] context_result;
        logic [15:0] context_reason;
        logic [63:0] syntax_uuid_low;
        logic [63:0] syntax_uuid_high;
        logic [15:0] syntax_major;
        logic [15:0] syntax_minor;
    } rbap_out_t;

    // Byte held in the input register, with its processing strobe.
    typedef struct packed {
        logic     valid;
        rbap_in_t data;
    } rbap_step_t;

    // Header check settings.
    typedef struct packed {
        logic [7:0] rpc_version;
        logic [7:0] packet_type;
        logic [7:0] flag_mask;
    } rbap_cfg_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_HEADER = 3'd1,
        ST_BODY_SHORT = 3'd2,
        ST_SEC_SHORT  = 3'd3,
        ST_LIST_SHORT = 3'd4,
        ST_NO_RESULT  = 3'd5,
        ST_REJECTED   = 3'd6
    } rbap_status_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_RPC_VERSION = 2'd0;
    localparam logic [1:0] CFG_PACKET_TYPE = 2'd1;
    localparam logic [1:0] CFG_FLAG_MASK   = 2'd2;

    localparam logic [7:0] RESET_RPC_VERSION = 8'd5;
    localparam logic [7:0] RESET_PACKET_TYPE = 8'd12;
    localparam logic [7:0] RESET_FLAG_MASK   = 8'd3;

    localparam logic [16:0] HDR_SIZE     = 17'd16;
    localparam logic [7:0]  DREP_BYTE    = 8'h10;
    localparam logic [15:0] MIN_BIND_ACK = 16'd36;
    localparam logic [17:0] RESULT_SPAN  = 18'd24;
    localparam logic [16:0] ALIGN_MASK   = 17'd3;
    localparam logic [16:0] POS_MAX      = 17'h1FFFF;
    localparam logic [16:0] SEC_BASE     = 17'd26;

endpackage
`default_nettype wire

@@ rtl/rbap_cfg_regs.sv @@
// Configuration registers for the header checks.
`default_nettype none
module rbap_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output rbap_pkg::rbap_cfg_t cfg
);
    import rbap_pkg::*;

    rbap_cfg_t cfg_reg;
    rbap_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    // Decode the write index; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RPC_VERSION: cfg_next.rpc_version = cfg_data;
                CFG_PACKET_TYPE: cfg_next.packet_type = cfg_data;
                CFG_FLAG_MASK:   cfg_next.flag_mask   = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rpc_version <= RESET_RPC_VERSION;
            cfg_reg.packet_type <= RESET_PACKET_TYPE;
            cfg_reg.flag_mask   <= RESET_FLAG_MASK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rbap_in_stage.sv @@
// Input register for received PDU bytes.
`default_nettype none
module rbap_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pdu_valid,
    output logic                 pdu_ready,
    input  rbap_pkg::rbap_in_t   pdu,
    input  logic                 advance,
    output rbap_pkg::rbap_step_t head
);
    import rbap_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    rbap_in_t data_reg;

    // Take a new request whenever the held one is empty or moving on.
    assign pdu_ready  = !valid_reg || advance;
    assign valid_next = pdu_ready ? pdu_valid : valid_reg;

    assign head.valid = valid_reg;
    assign head.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the next request is taken.
    always_ff @(posedge clk)
    begin
        if (pdu_valid && pdu_ready)
        begin
            data_reg <= pdu;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rbap_capture.sv @@
// Frame state, header checks, field capture and frame-end status.
`default_nettype none
module rbap_capture (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbap_pkg::rbap_cfg_t  cfg,
    input  rbap_pkg::rbap_step_t step,
    output logic                 done,
    output rbap_pkg::rbap_out_t  result
);
    import rbap_pkg::*;

    logic [16:0] pos_reg,     pos_next;
    logic        hdr_ok_reg,  hdr_ok_next;
    logic [15:0] frag_reg,    frag_next;
    logic [15:0] sec_reg,     sec_next;
    logic [16:0] rlo_reg,     rlo_next;
    logic [7:0]  count_reg,   count_next;
    logic [15:0] max_tx_reg,  max_tx_next;
    logic [15:0] max_rx_reg,  max_rx_next;
    logic [31:0] assoc_reg,   assoc_next;
    logic [15:0] ctx_res_reg, ctx_res_next;
    logic [15:0] ctx_rsn_reg, ctx_rsn_next;
    logic [63:0] uuid_lo_reg, uuid_lo_next;
    logic [63:0] uuid_hi_reg, uuid_hi_next;
    logic [15:0] major_reg,   major_next;
    logic [15:0] minor_reg,   minor_next;

    logic [7:0]   b;
    logic [16:0]  p;
    logic [16:0]  rel;
    logic [16:0]  rlo_sum;
    logic [16:0]  sec_end;
    logic [17:0]  list_end;
    logic [17:0]  span_end;
    rbap_status_t status;

    assign b    = step.data.rx_byte;
    assign p    = pos_reg;
    assign rel  = p - rlo_reg;
    assign done = step.valid && step.data.frame_end;

    // Apply this byte to the frame state.
    always_comb
    begin
        hdr_ok_next  = hdr_ok_reg;
        frag_next    = frag_reg;
        sec_next     = sec_reg;
        rlo_next     = rlo_reg;
        count_next   = count_reg;
        max_tx_next  = max_tx_reg;
        max_rx_next  = max_rx_reg;
        assoc_next   = assoc_reg;
        ctx_res_next = ctx_res_reg;
        ctx_rsn_next = ctx_rsn_reg;
        uuid_lo_next = uuid_lo_reg;
        uuid_hi_next = uuid_hi_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        rlo_sum      = SEC_BASE + {1'b0, b, sec_reg[7:0]} + ALIGN_MASK;

        if (p < HDR_SIZE)
        begin
            // Header checks and fragment length.
            if (p == 17'd0 && b != cfg.rpc_version)
                hdr_ok_next = 1'b0;
            if (p == 17'd2 && b != cfg.packet_type)
                hdr_ok_next = 1'b0;
            if (p == 17'd3 && (b & cfg.flag_mask) != cfg.flag_mask)
                hdr_ok_next = 1'b0;
            if (p == 17'd4 && b != DREP_BYTE)
                hdr_ok_next = 1'b0;
            if (p == 17'd8)
                frag_next[7:0] = b;
            if (p == 17'd9)
                frag_next[15:8] = b;
        end
        else if (p < {1'b0, frag_reg})
        begin
            if (p < 17'd18)
                max_tx_next[{p[0], 3'b000} +: 8] = b;
            else if (p < 17'd20)
                max_rx_next[{p[0], 3'b000} +: 8] = b;
            else if (p < 17'd24)
                assoc_next[{p[1:0], 3'b000} +: 8] = b;
            else if (p == 17'd24)
                sec_next[7:0] = b;
            else if (p == 17'd25)
            begin
                sec_next[15:8] = b;
                rlo_next       = rlo_sum & ~ALIGN_MASK;
            end
            else if (p >= rlo_reg && rel < 17'd28)
            begin
                // Result list: count, first result, transfer syntax.
                if (rel == 17'd0)
                    count_next = b;
                else if (rel >= 17'd4 && rel < 17'd6)
                    ctx_res_next[{rel[0], 3'b000} +: 8] = b;
                else if (rel >= 17'd6 && rel < 17'd8)
                    ctx_rsn_next[{rel[0], 3'b000} +: 8] = b;
                else if (rel >= 17'd8 && rel < 17'd16)
                    uuid_lo_next[{rel[2:0], 3'b000} +: 8] = b;
                else if (rel >= 17'd16 && rel < 17'd24)
                    uuid_hi_next[{rel[2:0], 3'b000} +: 8] = b;
                else if (rel >= 17'd24 && rel < 17'd26)
                    major_next[{rel[0], 3'b000} +: 8] = b;
                else if (rel >= 17'd26)
                    minor_next[{rel[0], 3'b000} +: 8] = b;
            end
        end

        // Count bytes, saturating.
        pos_next = (p == POS_MAX) ? p : p + 17'd1;
    end

    // Judge the frame from the state that includes the final byte.
    assign sec_end  = SEC_BASE + {1'b0, sec_next};
    assign list_end = {1'b0, rlo_next} + 18'd4;
    assign span_end = list_end + RESULT_SPAN;

    always_comb
    begin
        if (pos_next < HDR_SIZE || !hdr_ok_next || {1'b0, frag_next} < HDR_SIZE
            || {1'b0, frag_next} > pos_next)
            status = ST_BAD_HEADER;
        else if (frag_next < MIN_BIND_ACK)
            status = ST_BODY_SHORT;
        else if (sec_end > {1'b0, frag_next})
            status = ST_SEC_SHORT;
        else if (list_end > {2'b00, frag_next})
            status = ST_LIST_SHORT;
        else if (count_next == 8'd0 || span_end > {2'b00, frag_next})
            status = ST_NO_RESULT;
        else if (ctx_res_next != 16'd0)
            status = ST_REJECTED;
        else
            status = ST_OK;
    end

    // Drive the fields only for an accepted or rejected result.
    always_comb
    begin
        result        = '0;
        result.status = status;
        if (status == ST_OK || status == ST_REJECTED)
        begin
            result.max_transmit     = max_tx_next;
            result.max_receive      = max_rx_next;
            result.assoc_group      = assoc_next;
            result.context_result   = ctx_res_next;
            result.context_reason   = ctx_rsn_next;
            result.syntax_uuid_low  = uuid_lo_next;
            result.syntax_uuid_high = uuid_hi_next;
            result.syntax_major     = major_next;
            result.syntax_minor     = minor_next;
        end
    end

    // Advance the frame state; clear it after the final byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            hdr_ok_reg  <= 1'b1;
            frag_reg    <= '0;
            sec_reg     <= '0;
            rlo_reg     <= '0;
            count_reg   <= '0;
            max_tx_reg  <= '0;
            max_rx_reg  <= '0;
            assoc_reg   <= '0;
            ctx_res_reg <= '0;
            ctx_rsn_reg <= '0;
            uuid_lo_reg <= '0;
            uuid_hi_reg <= '0;
            major_reg   <= '0;
            minor_reg   <= '0;
        end
        else if (done)
        begin
            pos_reg     <= '0;
            hdr_ok_reg  <= 1'b1;
            frag_reg    <= '0;
            sec_reg     <= '0;
            rlo_reg     <= '0;
            count_reg   <= '0;
            max_tx_reg  <= '0;
            max_rx_reg  <= '0;
            assoc_reg   <= '0;
            ctx_res_reg <= '0;
            ctx_rsn_reg <= '0;
            uuid_lo_reg <= '0;
            uuid_hi_reg <= '0;
            major_reg   <= '0;
            minor_reg   <= '0;
        end
        else if (step.valid)
        begin
            pos_reg     <= pos_next;
            hdr_ok_reg  <= hdr_ok_next;
            frag_reg    <= frag_next;
            sec_reg     <= sec_next;
            rlo_reg     <= rlo_next;
            count_reg   <= count_next;
            max_tx_reg  <= max_tx_next;
            max_rx_reg  <= max_rx_next;
            assoc_reg   <= assoc_next;
            ctx_res_reg <= ctx_res_next;
            ctx_rsn_reg <= ctx_rsn_next;
            uuid_lo_reg <= uuid_lo_next;
            uuid_hi_reg <= uuid_hi_next;
            major_reg   <= major_next;
            minor_reg   <= minor_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rpc_bind_ack_parser_unit.sv @@
// Result: a frame_end byte is accepted into the input register, then the result register loads
// as that byte moves on, and the result can be taken from the result register.
// Throughput: one byte per cycle; a frame_end byte waits in the input register
// only while the previous result is still held in the result register.
// Reset: frame state is cleared, settings return to version 5, type 12,
// flag mask 3, and no result is pending; no clearing pass is needed.
`default_nettype none
`include "rpc_bind_ack_parser_unit_macros.svh"
module rpc_bind_ack_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                pdu_valid,
    output logic                pdu_ready,
    input  rbap_pkg::rbap_in_t  pdu,
    output logic                res_valid,
    input  logic                res_ready,
    output rbap_pkg::rbap_out_t res
);
    import rbap_pkg::*;

    rbap_cfg_t  cfg;
    rbap_step_t head;
    rbap_step_t step;
    logic       advance;
    logic       done;
    rbap_out_t  result;

    logic       res_valid_reg, res_valid_next;
    rbap_out_t  res_reg;

    rbap_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rbap_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .pdu_valid (pdu_valid),
        .pdu_ready (pdu_ready),
        .pdu       (pdu),
        .advance   (advance),
        .head      (head)
    );

    // Move a byte on unless it ends a frame and the result slot is full and not being taken.
    assign advance    = head.valid &&
                        (!head.data.frame_end || !res_valid_reg || res_ready);
    assign step.valid = advance;
    assign step.data  = head.data;

    rbap_capture u_capture (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .done   (done),
        .result (result)
    );

    // Result register: load on frame end, drop when taken.
    always_comb
    begin
        if (done)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // A blocked frame end stays in the input register.
    `RBAP_ASSERT(a_end_held, head.valid && head.data.frame_end && res_valid_reg && !res_ready |=> head.valid && head.data.frame_end)
    // A new result follows a frame-end byte.
    `RBAP_ASSERT(a_result_from_end, $rose(res_valid_reg) |-> $past(head.valid && head.data.frame_end))
    // Failed frames carry zero fields.
    `RBAP_ASSERT(a_fail_zero, res_valid_reg && res_reg.status != ST_OK && res_reg.status != ST_REJECTED |-> res_reg.max_transmit == 16'd0 && res_reg.assoc_group == 32'd0 && res_reg.syntax_uuid_low == 64'd0)
    // Rejection means a nonzero presentation result.
    `RBAP_ASSERT(a_reject_code, res_valid_reg && res_reg.status == ST_REJECTED |-> res_reg.context_result != 16'd0)
    // No result is pending once reset has been held over a clock edge.
    `RBAP_ASSERT_NR(a_reset_idle, !rst_n && !$past(rst_n) |-> !res_valid_reg)

endmodule
`default_nettype wire
